// ===== design/fcpa_pkg.sv =====
`timescale 1ns / 1ps

package fcpa_pkg;

    localparam int CB_W    = 17;  // chunk_bytes register width
    localparam int CNT_W   = 11;  // counts, run lengths and total_chunks
    localparam int IDX_W   = 10;  // chunk index fields
    localparam int OFF_W   = 26;  // byte offset field
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CB_W-1:0]  CHUNK_BYTES_RESET  = 17'd64;
    localparam logic [CNT_W-1:0] TOTAL_CHUNKS_RESET = 11'd1024;

    // Register indexes, taken from paddr[2].
    localparam logic REG_CHUNK_BYTES  = 1'b0;
    localparam logic REG_TOTAL_CHUNKS = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] chunk_index;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted_index;
        logic [OFF_W-1:0] byte_offset;
        logic [CNT_W-1:0] free_count;
    } t_rsp;

    // Configuration as seen by the allocator core.
    typedef struct packed {
        logic [CB_W-1:0]  chunk_bytes;
        logic [CNT_W-1:0] pool_size;   // total_chunks clamped to 1..MAX_CHUNKS
        logic             rebuild;     // one-cycle pulse after any register write
    } t_cfg;

endpackage

// ===== design/fixed_chunk_pool_allocator.sv =====
`timescale 1ns / 1ps

// Fixed chunk pool allocator.
//
// The request channel (i_in_valid / o_in_ready / i_in_data) carries one
// operation per request: allocate the chunk at the head of the free list,
// or free the chunk named in chunk_index. Each request yields exactly one
// result on the result channel (o_out_valid / i_out_ready / o_out_data) with
// a status, the chunk index, its byte offset and the free count afterwards.
// In the cycle a request is taken, the head entry is read from the
// list memory; the execute step that follows uses that entry and writes at
// most one entry back, and the result register loads at its end. A new
// request is taken only after the previous one has left the execute step,
// set by the read-then-write pass through the single list memory.
// If the receiver stalls, the result register holds its result; one more
// request is still accepted and waits in the execute step, with its memory
// write and head update held back, until the register frees.
// After reset, and in the cycle following any register write on the APB
// port, the list is one run of the clamped pool size starting at chunk 0;
// no request is taken during that rebuild cycle. No clearing pass is needed.
module fixed_chunk_pool_allocator #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcpa_pkg::APB_AW-1:0]  paddr,
    input  logic [fcpa_pkg::APB_DW-1:0]  pwdata,
    output logic [fcpa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fcpa_pkg::t_req               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output fcpa_pkg::t_rsp               o_out_data
);

    import fcpa_pkg::*;

    // Register block: chunk size, clamped pool size, and the rebuild strobe.
    t_cfg w_cfg;

    fcpa_regs #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer, head and count registers, list memory and result register.
    fcpa_core #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Each request occupies the memory for its read and its write-back pass, so
    // an accept is never followed directly by another.
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted in the cycle after an accept");

    // A rejected operation must not report a chunk.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_BAD_INDEX ||
                         o_out_data.status == ST_EMPTY))
        |-> (o_out_data.granted_index == '0 && o_out_data.byte_offset == '0))
        else $error("rejected operation carries a chunk index or offset");

    // No request is taken while the list is being rebuilt.
    a_no_accept_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.rebuild |-> !o_in_ready)
        else $error("request accepted during free list rebuild");

endmodule

// ===== design/fcpa_ram.sv =====
`timescale 1ns / 1ps

module fcpa_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fcpa_regs.sv =====
`timescale 1ns / 1ps

module fcpa_regs #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcpa_pkg::APB_AW-1:0]  paddr,
    input  logic [fcpa_pkg::APB_DW-1:0]  pwdata,
    output logic [fcpa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output fcpa_pkg::t_cfg               o_cfg
);

    import fcpa_pkg::*;

    logic [CB_W-1:0]  r_chunk_bytes;
    logic [CNT_W-1:0] r_total_chunks;
    logic             r_rebuild;
    logic             w_write;
    logic             w_index;
    logic [CNT_W-1:0] w_pool;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes  <= CHUNK_BYTES_RESET;
            r_total_chunks <= TOTAL_CHUNKS_RESET;
            r_rebuild      <= 1'b0;
        end else begin
            r_rebuild <= w_write;
            if (w_write) begin
                unique case (w_index)
                    REG_CHUNK_BYTES:  r_chunk_bytes  <= pwdata[CB_W-1:0];
                    REG_TOTAL_CHUNKS: r_total_chunks <= pwdata[CNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_index)
            REG_CHUNK_BYTES:  prdata = APB_DW'(r_chunk_bytes);
            REG_TOTAL_CHUNKS: prdata = APB_DW'(r_total_chunks);
            default:          prdata = '0;
        endcase
    end

    // A zero total counts as one chunk; anything above the pool depth is clamped.
    always_comb begin
        if (r_total_chunks == '0) begin
            w_pool = CNT_W'(1);
        end else if (32'(r_total_chunks) > MAX_CHUNKS) begin
            w_pool = CNT_W'(MAX_CHUNKS);
        end else begin
            w_pool = r_total_chunks;
        end
    end

    assign o_cfg.chunk_bytes = r_chunk_bytes;
    assign o_cfg.pool_size   = w_pool;
    assign o_cfg.rebuild     = r_rebuild;

endmodule

// ===== design/fcpa_core.sv =====
`timescale 1ns / 1ps

module fcpa_core #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcpa_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcpa_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fcpa_pkg::t_rsp o_out_data
);

    import fcpa_pkg::*;

    localparam int AW = $clog2(MAX_CHUNKS);
    localparam int LW = AW + 1;             // links and head also hold the empty marker
    localparam int EW = CNT_W + LW;         // entry: {run length, next link}
    localparam logic [LW-1:0] EMPTY_MARK = LW'(MAX_CHUNKS);
    localparam logic [CNT_W-1:0] RESET_POOL =
        (1024 > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : TOTAL_CHUNKS_RESET;

    t_state           r_state, n_state;
    logic [LW-1:0]    r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_e0_init, n_e0_init;
    t_req             r_req;
    logic             r_out_valid;
    t_rsp             r_out, n_out;

    logic             w_accept;
    logic             w_commit;
    logic             w_slot_free;
    logic             w_rd_en;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [EW-1:0]    w_wr_data;
    logic [EW-1:0]    w_ram_q;
    logic [EW-1:0]    w_entry;
    logic [CNT_W-1:0] w_len;
    logic [LW-1:0]    w_link;
    logic [LW-1:0]    w_next;
    logic [OFF_W-1:0] w_mul_idx;

    fcpa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CHUNKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (w_ram_q)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_cfg.rebuild;
                w_rd_en    = i_in_valid && !i_cfg.rebuild;
            end
            S_EXEC: w_commit = w_slot_free;
            default: ;
        endcase
    end

    // Entry zero holds the whole pool until it is first overwritten.
    assign w_entry = (r_e0_init && r_head == '0) ? {i_cfg.pool_size, EMPTY_MARK} : w_ram_q;
    assign w_len   = w_entry[LW +: CNT_W];
    assign w_link  = w_entry[LW-1:0];
    assign w_next  = r_head + LW'(1);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_e0_init = r_e0_init;
        w_wr_en   = 1'b0;
        w_wr_addr = r_req.chunk_index[AW-1:0];
        w_wr_data = {CNT_W'(1), r_head};
        w_mul_idx = '0;
        n_out.status        = ST_OK;
        n_out.granted_index = '0;
        if (r_req.mode == MODE_ALLOC) begin
            if (r_count == '0 || r_head >= EMPTY_MARK) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_out.granted_index = IDX_W'(r_head);
                w_mul_idx = OFF_W'(r_head);
                n_count   = r_count - CNT_W'(1);
                if (w_len > CNT_W'(1)) begin
                    if (w_next < EMPTY_MARK) begin
                        w_wr_en   = w_commit;
                        w_wr_addr = w_next[AW-1:0];
                        w_wr_data = {w_len - CNT_W'(1), w_link};
                        n_head    = w_next;
                    end else begin
                        n_head = EMPTY_MARK;
                    end
                end else begin
                    n_head = (w_link >= EMPTY_MARK) ? EMPTY_MARK : w_link;
                end
            end
        end else begin
            if ({1'b0, r_req.chunk_index} >= i_cfg.pool_size) begin
                n_out.status = ST_BAD_INDEX;
            end else begin
                w_wr_en   = w_commit;
                w_wr_addr = AW'(r_req.chunk_index);
                w_wr_data = {CNT_W'(1), r_head};
                n_head    = LW'(r_req.chunk_index);
                n_out.granted_index = r_req.chunk_index;
                w_mul_idx = OFF_W'(r_req.chunk_index);
                if (r_count != '1) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (r_req.chunk_index == '0) begin
                    n_e0_init = 1'b0;
                end
            end
        end
        n_out.byte_offset = OFF_W'(w_mul_idx * OFF_W'(i_cfg.chunk_bytes));
        n_out.free_count  = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= RESET_POOL;
            r_e0_init   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.rebuild) begin
                r_head    <= '0;
                r_count   <= i_cfg.pool_size;
                r_e0_init <= 1'b1;
            end else if (w_commit) begin
                r_head    <= n_head;
                r_count   <= n_count;
                r_e0_init <= n_e0_init;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
